@@ rtl/mlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpd_pkg
// Shared types and constants for the magic-word, length-prefixed packet
// deframer.
// ----------------------------------------------------------------------------
package mlpd_pkg;

  // Start-of-packet marker, big-endian on the wire.
  localparam logic [15:0] MAGIC_WORD = 16'hAA55;

  // Header bytes that follow the magic word: version, type, module, length.
  localparam int unsigned HDR_BYTES = 1 + 2 + 2 + 4;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES + 1);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

  // Header byte positions after the magic word.
  localparam logic [HDR_IDX_W-1:0] IDX_VERSION  = HDR_IDX_W'(0);
  localparam logic [HDR_IDX_W-1:0] IDX_TYPE_LO  = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] IDX_MODULE_LO = HDR_IDX_W'(4);

  // Result queue between the parser and the output port.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // One result transaction.
  typedef struct packed {
    logic        kind;
    logic [7:0]  version;
    logic [15:0] packet_type;
    logic [15:0] module_id;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
  } res_t;

  // Write side of the result queue.
  typedef struct packed {
    logic push;
    res_t res;
  } q_wr_t;

endpackage

@@ rtl/magic_length_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// magic_length_packet_deframer
// Deframes a byte stream into header and payload results for packets that
// start with the magic word 0xAA55 and carry a big-endian length field.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_rx_byte carries one received byte per
//   transaction. Bytes outside a packet that do not complete the magic word
//   are dropped without a result.
//   Output channel out_valid/out_ready/out_* carries one result per header
//   (out_kind = 0) and one per payload byte (out_kind = 1); out_last marks
//   the final result of each packet, including the header of an empty one.
//   Each result is written into the result queue when the byte that caused
//   it is accepted; the head of the queue drives the output.
//   Throughput: one byte per cycle while the result queue has room; the
//   parser makes a single state update per byte.
//   A four-entry result queue separates the parser from the output; in_ready
//   falls only when that queue is full, so the receiver may stall for up to
//   four results before the input is held off.
//   Reset (rst_n low, synchronous) empties the queue and puts the parser in
//   the hunting state with all header fields cleared.
// ----------------------------------------------------------------------------
module magic_length_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_version,
  output logic [15:0] out_packet_type,
  output logic [15:0] out_module_id,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_data_byte,
  output logic        out_last
);
  import mlpd_pkg::*;

  q_wr_t q_wr;
  logic  q_full;
  res_t  out_res;

  // Parser: hunt, header collection and payload tagging.
  mlpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  // Result queue feeding the output channel.
  mlpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_wr      (q_wr),
    .q_full    (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Split the result transaction onto the output ports.
  assign out_kind           = out_res.kind;
  assign out_version        = out_res.version;
  assign out_packet_type    = out_res.packet_type;
  assign out_module_id      = out_res.module_id;
  assign out_payload_length = out_res.payload_length;
  assign out_data_byte      = out_res.data_byte;
  assign out_last           = out_res.last;

endmodule

@@ rtl/mlpd_front.sv @@
// ----------------------------------------------------------------------------
// mlpd_front
// Byte parser: hunts for the magic word, collects the header and tags the
// payload bytes, pushing one result per header or payload byte.
// ----------------------------------------------------------------------------
module mlpd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 q_full,
  output mlpd_pkg::q_wr_t      q_wr
);
  import mlpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [7:0]            prev_byte_r, prev_byte_nxt;
  logic                  prev_valid_r, prev_valid_nxt;
  logic [HDR_IDX_W-1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]            version_r, version_nxt;
  logic [15:0]           type_r, type_nxt;
  logic [15:0]           module_r, module_nxt;
  logic [31:0]           length_r, length_nxt;
  logic [31:0]           remaining_r, remaining_nxt;
  logic                  accept;
  logic [7:0]            b;

  // The parser takes a byte whenever the queue has room.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_rx_byte;

  // Next-state and result logic for one accepted byte.
  always_comb begin
    phase_nxt      = phase_r;
    prev_byte_nxt  = prev_byte_r;
    prev_valid_nxt = prev_valid_r;
    hdr_idx_nxt    = hdr_idx_r;
    version_nxt    = version_r;
    type_nxt       = type_r;
    module_nxt     = module_r;
    length_nxt     = length_r;
    remaining_nxt  = remaining_r;
    q_wr.push      = 1'b0;
    q_wr.res       = '0;

    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          // Shift the byte into the field it belongs to.
          if (hdr_idx_r == IDX_VERSION) begin
            version_nxt = b;
          end else if (hdr_idx_r <= IDX_TYPE_LO) begin
            type_nxt = {type_r[7:0], b};
          end else if (hdr_idx_r <= IDX_MODULE_LO) begin
            module_nxt = {module_r[7:0], b};
          end else begin
            length_nxt = {length_r[23:0], b};
          end
          hdr_idx_nxt = hdr_idx_r + 1'b1;
          if (hdr_idx_r == HDR_LAST_IDX) begin
            // Header complete: emit the header result.
            hdr_idx_nxt                 = '0;
            q_wr.push                   = 1'b1;
            q_wr.res.kind               = KIND_HEADER;
            q_wr.res.version            = version_nxt;
            q_wr.res.packet_type        = type_nxt;
            q_wr.res.module_id          = module_nxt;
            q_wr.res.payload_length     = length_nxt;
            q_wr.res.data_byte          = '0;
            if (length_nxt == '0) begin
              q_wr.res.last  = 1'b1;
              phase_nxt      = PH_HUNT;
              prev_valid_nxt = 1'b0;
              prev_byte_nxt  = '0;
            end else begin
              q_wr.res.last = 1'b0;
              remaining_nxt = length_nxt;
              phase_nxt     = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // Pass the byte through, counting down to the last one.
          q_wr.push               = 1'b1;
          q_wr.res.kind           = KIND_PAYLOAD;
          q_wr.res.version        = version_r;
          q_wr.res.packet_type    = type_r;
          q_wr.res.module_id      = module_r;
          q_wr.res.payload_length = length_r;
          q_wr.res.data_byte      = b;
          if (remaining_r <= 32'd1) begin
            q_wr.res.last  = 1'b1;
            remaining_nxt  = '0;
            phase_nxt      = PH_HUNT;
            prev_valid_nxt = 1'b0;
            prev_byte_nxt  = '0;
          end else begin
            q_wr.res.last = 1'b0;
            remaining_nxt = remaining_r - 32'd1;
          end
        end
        default: begin
          // Slide the two-byte window looking for the magic word.
          if (prev_valid_r && ({prev_byte_r, b} == MAGIC_WORD)) begin
            phase_nxt      = PH_HEADER;
            hdr_idx_nxt    = '0;
            version_nxt    = '0;
            type_nxt       = '0;
            module_nxt     = '0;
            length_nxt     = '0;
            prev_valid_nxt = 1'b0;
            prev_byte_nxt  = '0;
          end else begin
            phase_nxt      = PH_HUNT;
            prev_byte_nxt  = b;
            prev_valid_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      prev_byte_r  <= '0;
      prev_valid_r <= 1'b0;
      hdr_idx_r    <= '0;
      version_r    <= '0;
      type_r       <= '0;
      module_r     <= '0;
      length_r     <= '0;
      remaining_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      prev_byte_r  <= prev_byte_nxt;
      prev_valid_r <= prev_valid_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      version_r    <= version_nxt;
      type_r       <= type_nxt;
      module_r     <= module_nxt;
      length_r     <= length_nxt;
      remaining_r  <= remaining_nxt;
    end
  end

  // The payload phase always has at least one byte still to come.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (remaining_r != '0))
    else $error("payload phase with zero bytes remaining");

  // A transaction marked last always sends the parser back to hunting.
  a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && q_wr.res.last) |=> (phase_r == PH_HUNT && !prev_valid_r))
    else $error("last result did not restart the hunt");

  // Header results only come out at the final header byte.
  a_header_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && q_wr.res.kind == KIND_HEADER) |->
      (phase_r == PH_HEADER && hdr_idx_r == HDR_LAST_IDX))
    else $error("header result emitted before header complete");

endmodule

@@ rtl/mlpd_queue.sv @@
// ----------------------------------------------------------------------------
// mlpd_queue
// Short result queue between the parser and the output port; its head
// drives the output channel directly.
// ----------------------------------------------------------------------------
module mlpd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mlpd_pkg::q_wr_t  q_wr,
  output logic             q_full,
  output logic             out_valid,
  input  logic             out_ready,
  output mlpd_pkg::res_t   out_res
);
  import mlpd_pkg::*;

  res_t               entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               pop;

  assign q_full    = (count_r == QCNT_W'(QDEPTH));
  assign out_valid = (count_r != '0);
  assign out_res   = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (q_wr.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !q_wr.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      entry_r[wr_ptr_r] <= q_wr.res;
    end
  end

  // The parser never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("push into full result queue");

  // Occupancy never exceeds the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  // Occupancy tracks the pointers.
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
    else $error("result queue count disagrees with pointers");

endmodule
